FILE: rtl/assert_macros.svh
// Assertion macros for the checker of the level meter.
// No dependencies; every use needs clk_i and rst_ni in scope for BPRM_ASSERT.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define BPRM_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("level meter assertion failed");

// Concurrent assertion on the usual clk_i and rst_ni.
`define BPRM_ASSERT(lbl, prop) `BPRM_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

FILE: rtl/bprm_pkg.sv
// Shared types and constants of the block peak and RMS level meter.
// No dependencies; used by every module of the block.
package bprm_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned MAX_BLOCK   = 4096;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_valid;
    logic                          last;
  } in_req_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] peak_level;
    logic [SAMPLE_BITS-1:0] rms_level;
  } out_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_ROOT,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_DIV,
    DS_SQRT,
    DS_DONE
  } ds_state_e;

endpackage

FILE: rtl/bprm_divsqrt.sv
// Mean-square divide and floor square root, one bit per cycle on one shared subtractor.
// Depends on bprm_pkg for the sequencer state type.
module bprm_divsqrt #(
  parameter int unsigned SampleBits = bprm_pkg::SAMPLE_BITS,
  parameter int unsigned SumW       = 59,
  parameter int unsigned CntW       = 13
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SumW-1:0]       sum_i,
  input  logic [CntW-1:0]       count_i,
  output logic                  done_o,
  output logic [SampleBits-1:0] root_o
);

  // The quotient is a mean square, never above (2^(SampleBits-1))^2.
  localparam int unsigned QW    = 2 * SampleBits - 1;
  localparam int unsigned UW    = QW + 1;
  localparam int unsigned StepW = $clog2(SumW);

  bprm_pkg::ds_state_e state_q, state_d;

  logic [SumW-1:0]  dvd_q, dvd_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  dsr_q, dsr_d;
  logic [StepW-1:0] step_q, step_d;
  logic [QW-1:0]    x_q, x_d;
  logic [QW-1:0]    res_q, res_d;
  logic [QW-1:0]    bit_q, bit_d;

  // Shared unit: one subtract and compare, used by both the divide and the root.
  logic [UW-1:0] op_a, op_b;
  logic [UW:0]   diff;
  logic          ge;
  logic [CntW:0] part_rem;

  assign diff     = {1'b0, op_a} - {1'b0, op_b};
  assign ge       = ~diff[UW];
  assign part_rem = {rem_q, dvd_q[SumW-1]};

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      bprm_pkg::DS_DIV: begin
        op_a = UW'(part_rem);
        op_b = UW'(dsr_q);
      end
      bprm_pkg::DS_SQRT: begin
        op_a = UW'(x_q);
        op_b = UW'(res_q) + UW'(bit_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    step_d  = step_q;
    x_d     = x_q;
    res_d   = res_q;
    bit_d   = bit_q;
    done_o  = 1'b0;
    case (state_q)
      bprm_pkg::DS_IDLE: begin
        if (start_i) begin
          dvd_d   = sum_i;
          dsr_d   = count_i;
          rem_d   = '0;
          step_d  = StepW'(SumW - 1);
          state_d = bprm_pkg::DS_DIV;
        end
      end
      bprm_pkg::DS_DIV: begin
        // Restoring division: quotient bits shift into the low end of the dividend.
        rem_d  = ge ? diff[CntW-1:0] : part_rem[CntW-1:0];
        dvd_d  = {dvd_q[SumW-2:0], ge};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          x_d     = dvd_d[QW-1:0];
          res_d   = '0;
          bit_d   = QW'(1) << (QW - 1);
          step_d  = StepW'(SampleBits - 1);
          state_d = bprm_pkg::DS_SQRT;
        end
      end
      bprm_pkg::DS_SQRT: begin
        if (ge) begin
          x_d   = diff[QW-1:0];
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d  = bit_q >> 2;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = bprm_pkg::DS_DONE;
        end
      end
      bprm_pkg::DS_DONE: begin
        done_o  = 1'b1;
        state_d = bprm_pkg::DS_IDLE;
      end
      default: begin
        state_d = bprm_pkg::DS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bprm_pkg::DS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    step_q <= step_d;
    x_q    <= x_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
  end

  assign root_o = res_q[SampleBits-1:0];

endmodule

FILE: rtl/block_peak_rms_meter_core.sv
// Block peak and RMS level meter, top level.
// Depends on bprm_pkg and bprm_divsqrt.
//
// Usage: audio samples come in as requests on the input channel (valid and
// ready), one signed sample with a sample_valid flag and a last flag each.
// A counted sample updates the peak magnitude, the sum of squares and the
// sample count. A request with last set closes the block (its own sample is
// counted first if valid) and yields one request on the output channel with
// the peak and the floor square root of the mean square. All accumulators
// then clear. Samples past MaxBlock in one block are ignored.
//
// A request without last is captured, then multiplied and accumulated; the
// input is not ready again until that is done. A closing request then runs
// the shared subtractor in bprm_divsqrt, which does one quotient bit and then
// one root bit per cycle, before the output request shows. An empty block
// skips the divider and closes with zeros.
//
// Reset clears the accumulators and the output valid; the block is ready in
// the first cycle after reset. The output register parts the two channels:
// while a result waits, new samples of the next block are taken, and only a
// second closing request waits in its final cycle for the output to drain.
module block_peak_rms_meter_core #(
  parameter int unsigned MaxBlock = bprm_pkg::MAX_BLOCK
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bprm_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bprm_pkg::out_req_t out_req_o
);

  localparam int unsigned SB   = bprm_pkg::SAMPLE_BITS;
  // The count must hold MaxBlock itself; the sum holds MaxBlock full-scale squares.
  localparam int unsigned CntW = $clog2(MaxBlock + 1);
  localparam int unsigned SumW = 2 * SB - 2 + $clog2(MaxBlock) + 1;

  bprm_pkg::state_e state_q, state_d;

  logic [SB-1:0]     mag_q;
  logic [SB-1:0]     mag_in;
  logic [SB-1:0]     raw;
  logic              take_q;
  logic              last_q;
  logic [SB-1:0]     peak_q, peak_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [2*SB-1:0]   square;
  logic              out_valid_q, out_valid_d;
  bprm_pkg::out_req_t out_q, out_d;
  logic              out_load;
  logic              in_fire;
  logic              ds_start;
  logic              ds_done;
  logic [SB-1:0]     ds_root;

  // Magnitude of the incoming sample; full-scale negative maps to 2^(SB-1).
  assign raw     = in_req_i.sample;
  assign mag_in  = raw[SB-1] ? (~raw + 1'b1) : raw;
  assign in_fire = in_valid_i && in_ready_o;
  assign square  = mag_q * mag_q;

  always_comb begin
    state_d     = state_q;
    peak_d      = peak_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    out_load    = 1'b0;
    in_ready_o  = 1'b0;
    ds_start    = 1'b0;
    case (state_q)
      bprm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = bprm_pkg::ST_ACC;
        end
      end
      bprm_pkg::ST_ACC: begin
        if (take_q) begin
          if (mag_q > peak_q) begin
            peak_d = mag_q;
          end
          sum_d = sum_q + SumW'(square);
          cnt_d = cnt_q + 1'b1;
        end
        if (!last_q) begin
          state_d = bprm_pkg::ST_IDLE;
        end else if (cnt_d != '0) begin
          ds_start = 1'b1;
          state_d  = bprm_pkg::ST_ROOT;
        end else begin
          state_d = bprm_pkg::ST_FIN;
        end
      end
      bprm_pkg::ST_ROOT: begin
        if (ds_done) begin
          state_d = bprm_pkg::ST_FIN;
        end
      end
      bprm_pkg::ST_FIN: begin
        // Hand the levels to the output register once it is free.
        if (!out_valid_q || out_ready_i) begin
          out_load         = 1'b1;
          out_valid_d      = 1'b1;
          out_d.peak_level = peak_q;
          out_d.rms_level  = (cnt_q == '0) ? '0 : ds_root;
          peak_d           = '0;
          sum_d            = '0;
          cnt_d            = '0;
          state_d          = bprm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bprm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bprm_pkg::ST_IDLE;
      peak_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      peak_q      <= peak_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mag_q  <= mag_in;
      take_q <= in_req_i.sample_valid && (cnt_q < CntW'(MaxBlock));
      last_q <= in_req_i.last;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  bprm_divsqrt #(
    .SampleBits(SB),
    .SumW      (SumW),
    .CntW      (CntW)
  ) u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ds_start),
    .sum_i  (sum_d),
    .count_i(cnt_d),
    .done_o (ds_done),
    .root_o (ds_root)
  );

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

FILE: rtl/bprm_checker.sv
// Port-level checker for the level meter, bound to the top level.
// Depends on bprm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bprm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input bprm_pkg::in_req_t  in_req_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input bprm_pkg::out_req_t out_req_o
);

  // A stalled result stays offered and unchanged.
  `BPRM_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_req_o)))

  // A taken request leaves the input not ready while its sample is accumulated.
  `BPRM_ASSERT(a_busy_after_take, (in_valid_i && in_ready_o) |=> !in_ready_o)

  // The mean square never exceeds the largest square, so the RMS stays at or below the peak.
  `BPRM_ASSERT(a_rms_le_peak, out_valid_o |-> (out_req_o.rms_level <= out_req_o.peak_level))

  // A magnitude never exceeds full scale.
  `BPRM_ASSERT(a_peak_range, out_valid_o |-> (out_req_o.peak_level <= 24'h800000))

endmodule

bind block_peak_rms_meter_core bprm_checker u_bprm_checker (.*);
